/* design/contiguous_block_allocator_macros.svh */
// Assertion macros for the contiguous block allocator.
// Taken in by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBA_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/cba_pkg.sv */
// Shared types and constants of the contiguous block allocator.
// Used by the map cell, the serial divider and the top level; no dependencies.
package cba_pkg;

   localparam int SIZE_W     = 24;
   localparam int BS_W       = 17;
   localparam int DIV_CNT_W  = 5;
   localparam int START_W    = 10;
   localparam int TAKEN_W    = 11;
   localparam int TAKEN_MAX  = 2047;
   localparam int BS_RESET   = 1024;
   localparam int DATA_W     = 24;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIV    = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_RESULT = 4'b1000
   } cba_state_type;

   typedef struct packed {
      logic shift;
      logic mark;
   } cba_cell_ctl_type;

   typedef struct packed {
      logic              done;
      logic [SIZE_W-1:0] quot;
      logic              rem_nz;
   } cba_div_res_type;

endpackage

/* design/cba_cell.sv */
// One cell of the used-block ring: holds one used bit and hands it to its neighbor.
// Depends on cba_pkg for the control struct.
module cba_cell
   import cba_pkg::*;
#(
   parameter int   DIST      = 0,
   parameter int   CW        = 11,
   parameter logic RESET_VAL = 1'b0
) (
   input  logic             clock,
   input  logic             reset,
   input  cba_cell_ctl_type ctl,
   input  logic [CW-1:0]    mark_len,
   input  logic             shift_in,
   output logic             used_out
);

   logic used_ff;
   logic used_in;

   always_comb begin
      used_in = used_ff;
      if (ctl.shift) begin
         if (ctl.mark && (CW'(DIST) < mark_len)) begin
            used_in = 1'b1;
         end else begin
            used_in = shift_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= RESET_VAL;
      end else begin
         used_ff <= used_in;
      end
   end

   assign used_out = used_ff;

endmodule

/* design/cba_ceil_div.sv */
// Restoring divider, one quotient bit per cycle: size by block size.
// Depends on cba_pkg for widths and the result struct.
module cba_ceil_div
   import cba_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SIZE_W-1:0] dividend,
   input  logic [BS_W-1:0]   divisor,
   output cba_div_res_type   res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SIZE_W-1:0]    quot_ff, quot_in;
   logic [BS_W-1:0]      rem_ff, rem_in;
   logic [BS_W-1:0]      dvs_ff, dvs_in;
   logic [BS_W:0]        rem_sh;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff, quot_ff[SIZE_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[SIZE_W-2:0], ge};
         rem_in  = ge ? BS_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[BS_W-1:0];
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(SIZE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign res.done   = done_ff;
   assign res.quot   = quot_ff;
   assign res.rem_nz = |rem_ff;

endmodule

/* design/contiguous_block_allocator.sv */
// First-fit contiguous block allocator over a ring of used-block cells.
// Depends on cba_pkg, cba_cell, cba_ceil_div and the assertion macro header.
//
// Usage:
//   req channel: one transaction carries a size in bytes (req_tdata).
//   rsp channel: one transaction per request: start block and blocks taken in
//     rsp_tdata, the granted flag in rsp_tuser.
//   csr channel: writes the bytes-per-block register; write only while idle.
// Steps per request: the request is taken in the idle state; the divide state
//   waits while the divider forms all 24 quotient bits and then hands over the
//   rounded block count; the scan state rotates the map ring once past the head
//   cell; the result register is then loaded. A request larger than the map
//   skips the scan. A new request is taken only in the idle state, so the block
//   does not take one before the last has reached the result register.
// The run is marked in the cycle it is found: the cells just behind the head
//   set their bits in parallel while the ring keeps rotating.
// Reset: map free except blocks 0 and 1 (reserved), block size 1024.
// Receiver stall: the result waits in the output register; the next request is
//   still taken and runs until its own result is ready, then holds.
`include "contiguous_block_allocator_macros.svh"
module contiguous_block_allocator
   import cba_pkg::*;
#(
   parameter int NUM_BLOCKS = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // [23:0] size_value
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // [9:0] start_block, [20:10] blocks_taken, rest 0
   output logic [0:0]        rsp_tuser,   // [0] granted
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [BS_W-1:0]   csr_wdata    // [16:0] block_size
);

   localparam int PW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW = $clog2(NUM_BLOCKS + 1);

   cba_state_type       state_ff, state_in;
   logic [BS_W-1:0]     bs_ff, bs_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [SIZE_W-1:0]   need_ff, need_in;
   logic [CW-1:0]       run_ff, run_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PW-1:0]       start_ff, start_in;
   logic                found_ff, found_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [0:0]          rsp_tuser_ff, rsp_tuser_in;

   logic                div_start;
   logic [BS_W-1:0]     divisor;
   cba_div_res_type     div_res;
   logic [SIZE_W-1:0]   need_calc;
   logic [CW-1:0]       run_next;
   logic [CW-1:0]       start_calc;
   logic                mark;
   logic                rsp_load;
   logic [31:0]         start_wide;
   logic [TAKEN_W-1:0]  taken;
   cba_cell_ctl_type    cell_ctl;
   logic [NUM_BLOCKS-1:0] used;

   assign divisor   = (bs_ff == '0) ? BS_W'(1) : bs_ff;
   assign div_start = req_tvalid && req_tready;

   cba_ceil_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_tdata[SIZE_W-1:0]),
      .divisor  (divisor),
      .res      (div_res)
   );

   for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
      cba_cell #(
         .DIST      (NUM_BLOCKS - 1 - k),
         .CW        (CW),
         .RESET_VAL ((k < 2) ? 1'b1 : 1'b0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .mark_len (need_ff[CW-1:0]),
         .shift_in (used[(k + 1) % NUM_BLOCKS]),
         .used_out (used[k])
      );
   end

   always_comb begin
      need_calc  = (size_ff == '0) ? SIZE_W'(1) : (div_res.quot + SIZE_W'(div_res.rem_nz));
      run_next   = used[0] ? '0 : (run_ff + CW'(1));
      mark       = (state_ff == ST_SCAN) && !found_ff && (run_next == need_ff[CW-1:0]);
      start_calc = CW'(pos_ff) + CW'(1) - need_ff[CW-1:0];
      cell_ctl.shift = (state_ff == ST_SCAN);
      cell_ctl.mark  = mark;
      start_wide = 32'(start_ff);
      taken      = (need_ff > SIZE_W'(TAKEN_MAX)) ? TAKEN_W'(TAKEN_MAX) : need_ff[TAKEN_W-1:0];
      rsp_load   = (state_ff == ST_RESULT) && (!rsp_tvalid_ff || rsp_tready);

      state_in      = state_ff;
      bs_in         = (csr_valid && csr_ready) ? csr_wdata : bs_ff;
      size_in       = size_ff;
      need_in       = need_ff;
      run_in        = run_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      found_in      = found_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               size_in  = req_tdata[SIZE_W-1:0];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               need_in  = need_calc;
               run_in   = '0;
               pos_in   = '0;
               start_in = '0;
               found_in = 1'b0;
               if ({1'b0, need_calc} > (SIZE_W + 1)'(NUM_BLOCKS)) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (!found_ff) begin
               run_in = run_next;
            end
            if (mark) begin
               found_in = 1'b1;
               start_in = start_calc[PW-1:0];
            end
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(NUM_BLOCKS - 1)) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (rsp_load) begin
               rsp_tdata_in  = {(DATA_W - START_W - TAKEN_W)'(0), taken,
                                start_wide[START_W-1:0]};
               rsp_tuser_in  = found_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bs_ff         <= BS_W'(BS_RESET);
         found_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bs_ff         <= bs_in;
         found_ff      <= found_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      size_ff      <= size_in;
      need_ff      <= need_in;
      run_ff       <= run_in;
      pos_ff       <= pos_in;
      start_ff     <= start_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `CBA_ASSERT(a_reserved_kept, state_ff == ST_IDLE, used[0] && used[1], "reserved block freed")
   `CBA_ASSERT(a_run_below_need, (state_ff == ST_SCAN) && !found_ff,
               run_ff < need_ff[CW-1:0], "run passed need unseen")
   `CBA_ASSERT(a_start_past_reserved, (state_ff == ST_RESULT) && found_ff,
               start_ff >= PW'(2), "run over reserved blocks")
   `CBA_ASSERT(a_div_done_in_div, div_res.done, state_ff == ST_DIV, "divider done outside divide")
   `CBA_ASSERT_NEXT(a_result_loaded, rsp_load, rsp_tvalid_ff && (state_ff == ST_IDLE),
                    "result not presented")

endmodule
